// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file dfe_checker.sv.
// Needs nothing else; take it in by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define DFE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dfe assertion failed");

// Condition must never be true at a rising edge outside reset.
`define DFE_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `DFE_ASSERT(lbl, clk, rst_n, !(cond))

`endif

// ----- hdl/dfe_pkg.sv -----
// Shared types and constants of the delimited field extractor.
// Used by the interfaces, the window cell and the top level.
package dfe_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned FIELD_W    = 16;
  localparam int unsigned CNT_W      = 17;

  localparam logic [CFG_IDX_W-1:0] REG_DELIM_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_NUM   = 2'd2;

  localparam logic [7:0] DELIM_RESET = 8'd44;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_POP,
    ACT_POP_INS,
    ACT_INS,
    ACT_TERM
  } act_e;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

// ----- hdl/dfe_if.sv -----
// Stream and configuration channel interfaces of the field extractor.
// Depends on dfe_pkg for the configuration widths.
interface dfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       byte_present;
  logic       end_of_string;

  modport source (output valid, in_byte, byte_present, end_of_string, input ready);
  modport sink   (input valid, in_byte, byte_present, end_of_string, output ready);
endinterface

interface dfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_present;
  logic       out_last;

  modport source (output valid, out_byte, out_present, out_last, input ready);
  modport sink   (input valid, out_byte, out_present, out_last, output ready);
endinterface

interface dfe_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [dfe_pkg::CFG_IDX_W-1:0]    index;
  logic [dfe_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/dfe_cell.sv -----
// One byte cell of the delimiter match window.
// Shifts toward the window head, takes the new byte, compares with its delimiter byte.
module dfe_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dfe_pkg::cell_ctrl_t ctrl_i,
  input  logic                wr_i,
  input  logic [7:0]          wr_byte_i,
  input  logic [7:0]          next_byte_i,
  input  logic [7:0]          delim_byte_i,
  output logic [7:0]          byte_o,
  output logic                eq_o
);

  logic [7:0] byte_q;
  logic [7:0] byte_d;

  always_comb begin
    if (wr_i) begin
      byte_d = wr_byte_i;
    end else if (ctrl_i.shift) begin
      byte_d = next_byte_i;
    end else begin
      byte_d = byte_q;
    end
  end

  assign eq_o   = (byte_d == delim_byte_i);
  assign byte_o = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'h00;
    end else begin
      byte_q <= ctrl_i.clear ? 8'h00 : byte_d;
    end
  end

endmodule

// ----- hdl/delimited_field_extract.sv -----
// Delimited field extractor: returns the bytes of one numbered field of a byte string.
// Items follow back to back; a held item first pops each byte held beyond a shortened
// delimiter length, then takes in its byte if it has one, and at a string end pops every byte
// left in the window and then emits the terminator.
// Output is registered and appears in the cycle after the one that produces it; a full output stage stalls input.
// rst_ni clears the window, field counter and handshake state; config returns to ',' len 1, field 0.
module delimited_field_extract #(
  parameter int unsigned DELIM_MAX = 8
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  dfe_in_if.sink    in_i,
  dfe_cfg_if.sink   cfg_i,
  dfe_out_if.source out_o
);

  localparam int unsigned FW = $clog2(DELIM_MAX + 1);
  localparam logic [dfe_pkg::CNT_W-1:0] CNT_MAX = '1;

  logic [dfe_pkg::CFG_DATA_W-1:0] delim_q;
  logic [dfe_pkg::LEN_W-1:0]      len_q;
  logic [dfe_pkg::FIELD_W-1:0]    field_q;

  logic                           pend_q;
  logic [7:0]                     b_q;
  logic                           pres_q;
  logic                           last_q;
  logic                           ins_done_q;
  logic                           ins_done_d;

  logic [FW-1:0]                  fill_q;
  logic [FW-1:0]                  fill_d;
  logic [dfe_pkg::CNT_W-1:0]      cnt_q;
  logic [dfe_pkg::CNT_W-1:0]      cnt_d;

  logic                           out_valid_q;
  logic [7:0]                     out_byte_q;
  logic                           out_present_q;
  logic                           out_last_q;

  logic [FW-1:0]                  len_eff;
  logic                           sel;
  dfe_pkg::act_e                  act;
  logic                           emit;
  logic                           go;
  logic                           done;
  logic                           accept;
  logic                           is_pop;
  logic                           is_ins;
  logic [FW-1:0]                  ins_pos;
  logic [FW-1:0]                  fill_ins;
  logic                           match;
  dfe_pkg::cell_ctrl_t            cell_ctrl;
  logic [DELIM_MAX-1:0][7:0]      win;
  logic [DELIM_MAX-1:0]           eq;
  logic [DELIM_MAX-1:0]           mask;

  assign len_eff = (len_q > dfe_pkg::LEN_W'(DELIM_MAX)) ? FW'(DELIM_MAX) : FW'(len_q);
  assign sel     = (len_eff != '0) && (cnt_q == {1'b0, field_q});

  always_comb begin
    act = dfe_pkg::ACT_NONE;
    if (pend_q) begin
      if (pres_q && (len_eff != '0) && !ins_done_q) begin
        if (fill_q > len_eff) begin
          act = dfe_pkg::ACT_POP;
        end else if (fill_q == len_eff) begin
          act = dfe_pkg::ACT_POP_INS;
        end else begin
          act = dfe_pkg::ACT_INS;
        end
      end else if (last_q) begin
        act = (fill_q != '0) ? dfe_pkg::ACT_POP : dfe_pkg::ACT_TERM;
      end
    end
  end

  assign is_pop = (act == dfe_pkg::ACT_POP) || (act == dfe_pkg::ACT_POP_INS);
  assign is_ins = (act == dfe_pkg::ACT_INS) || (act == dfe_pkg::ACT_POP_INS);
  assign emit   = (is_pop && sel) || (act == dfe_pkg::ACT_TERM);
  assign go     = !emit || !out_valid_q || out_o.ready;
  assign done   = pend_q && go && ((act == dfe_pkg::ACT_NONE) || (act == dfe_pkg::ACT_TERM) ||
                                   (is_ins && !last_q));

  assign in_i.ready = !pend_q || done;
  assign accept     = in_i.valid && in_i.ready;

  assign ins_pos  = (act == dfe_pkg::ACT_POP_INS) ? fill_q - FW'(1) : fill_q;
  assign fill_ins = (act == dfe_pkg::ACT_POP_INS) ? fill_q : fill_q + FW'(1);

  always_comb begin
    for (int i = 0; i < DELIM_MAX; i++) begin
      mask[i] = (FW'(i) < len_eff);
    end
  end

  assign match           = go && is_ins && (fill_ins == len_eff) && (&(eq | ~mask));
  assign cell_ctrl.shift = go && is_pop;
  assign cell_ctrl.clear = match;

  for (genvar i = 0; i < DELIM_MAX; i++) begin : g_cell
    logic [7:0] next_byte;
    if (i == DELIM_MAX - 1) begin : g_tail
      assign next_byte = 8'h00;
    end else begin : g_body
      assign next_byte = win[i+1];
    end
    dfe_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl),
      .wr_i         (go && is_ins && (ins_pos == FW'(i))),
      .wr_byte_i    (b_q),
      .next_byte_i  (next_byte),
      .delim_byte_i (delim_q[8*i +: 8]),
      .byte_o       (win[i]),
      .eq_o         (eq[i])
    );
  end

  always_comb begin
    fill_d = fill_q;
    cnt_d  = cnt_q;
    if (go) begin
      case (act)
        dfe_pkg::ACT_POP: begin
          fill_d = fill_q - FW'(1);
        end
        dfe_pkg::ACT_POP_INS, dfe_pkg::ACT_INS: begin
          fill_d = match ? '0 : fill_ins;
          if (match && (cnt_q != CNT_MAX)) begin
            cnt_d = cnt_q + dfe_pkg::CNT_W'(1);
          end
        end
        dfe_pkg::ACT_TERM: begin
          fill_d = '0;
          cnt_d  = '0;
        end
        default: begin
          fill_d = fill_q;
        end
      endcase
    end
  end

  always_comb begin
    ins_done_d = ins_done_q;
    if (accept) begin
      ins_done_d = 1'b0;
    end else if (go && is_ins && last_q) begin
      ins_done_d = 1'b1;
    end
  end

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q    <= dfe_pkg::CFG_DATA_W'(dfe_pkg::DELIM_RESET);
      len_q      <= dfe_pkg::LEN_W'(1);
      field_q    <= '0;
      pend_q     <= 1'b0;
      ins_done_q <= 1'b0;
      fill_q     <= '0;
      cnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.index)
          dfe_pkg::REG_DELIM_BYTES: delim_q <= cfg_i.data;
          dfe_pkg::REG_DELIM_LEN:   len_q   <= cfg_i.data[dfe_pkg::LEN_W-1:0];
          dfe_pkg::REG_FIELD_NUM:   field_q <= cfg_i.data[dfe_pkg::FIELD_W-1:0];
          default:                  len_q   <= len_q;
        endcase
      end
      if (accept) begin
        pend_q <= 1'b1;
      end else if (done) begin
        pend_q <= 1'b0;
      end
      ins_done_q <= ins_done_d;
      fill_q     <= fill_d;
      cnt_q      <= cnt_d;
      if (go && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_q    <= in_i.in_byte;
      pres_q <= in_i.byte_present;
      last_q <= in_i.end_of_string;
    end
    if (go && emit) begin
      out_byte_q    <= (act == dfe_pkg::ACT_TERM) ? 8'h00 : win[0];
      out_present_q <= (act != dfe_pkg::ACT_TERM);
      out_last_q    <= (act == dfe_pkg::ACT_TERM);
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_byte    = out_byte_q;
  assign out_o.out_present = out_present_q;
  assign out_o.out_last    = out_last_q;

endmodule

// ----- hdl/dfe_checker.sv -----
// Port-level checks of the delimited field extractor output channel.
// Depends on assert_macros.svh; bound to delimited_field_extract below.
`include "assert_macros.svh"

module dfe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       out_present_i,
  input logic       out_last_i
);

  `DFE_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i)
  `DFE_ASSERT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i |=> $stable(out_byte_i) && $stable(out_last_i))
  `DFE_ASSERT(a_out_kind, clk_i, rst_ni, out_valid_i |-> (out_present_i != out_last_i))
  `DFE_ASSERT_NEVER(a_term_zero, clk_i, rst_ni, out_valid_i && out_last_i && (out_byte_i != 8'h00))

endmodule

bind delimited_field_extract dfe_checker u_dfe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_byte_i    (out_o.out_byte),
  .out_present_i (out_o.out_present),
  .out_last_i    (out_o.out_last)
);
